// ===== design/glcm_pkg.sv =====
// ----------------------------------------------------------------------------
// glcm_pkg
// shared constants, codes and helpers of the co-occurrence accumulator
// ----------------------------------------------------------------------------
package glcm_pkg;

    localparam int GRAY_LEVELS  = 16;
    localparam int LEVEL_BITS   = $clog2(GRAY_LEVELS);
    localparam int PIXEL_BITS   = 8;
    localparam int LEVEL_DIVISOR = 16;
    localparam int MAX_WIDTH    = 1024;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int HEIGHT_LIMIT = 1024;
    localparam int ROW_BITS     = $clog2(HEIGHT_LIMIT);
    localparam int SIZE_BITS    = 11;
    localparam int COUNT_BITS   = 20;
    localparam int OUT_BITS     = 20;
    localparam int TABLE_DEPTH  = GRAY_LEVELS * GRAY_LEVELS;
    localparam int TABLE_ADDR_BITS = 2 * LEVEL_BITS;

    // stream payload layout
    localparam int IN_DATA_BITS  = 24;
    localparam int OUT_DATA_BITS = 24;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = SIZE_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DIRECTION    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUANTIZE     = 2'd3;

    // pair directions
    localparam logic [1:0] DIR_HORIZONTAL = 2'd0;
    localparam logic [1:0] DIR_VERTICAL   = 2'd1;
    localparam logic [1:0] DIR_DIAG_45    = 2'd2;
    localparam logic [1:0] DIR_DIAG_135   = 2'd3;

    // item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    typedef logic [LEVEL_BITS-1:0]      level_t;
    typedef logic [COUNT_BITS-1:0]      count_t;
    typedef logic [TABLE_ADDR_BITS-1:0] table_addr_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    // pixel to gray level, quantized or saturated
    function automatic level_t to_level(input logic [PIXEL_BITS-1:0] pix, input logic quant);
        logic [PIXEL_BITS-1:0] lv;
        lv = quant ? PIXEL_BITS'(pix / LEVEL_DIVISOR) : pix;
        if (lv > PIXEL_BITS'(GRAY_LEVELS - 1))
        begin
            lv = PIXEL_BITS'(GRAY_LEVELS - 1);
        end
        return lv[LEVEL_BITS-1:0];
    endfunction

endpackage

// ===== design/glcm_ram.sv =====
// ----------------------------------------------------------------------------
// glcm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module glcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/glcm_cooccurrence_accumulator_unit.sv =====
// ----------------------------------------------------------------------------
// glcm_cooccurrence_accumulator_unit
// 16-level gray co-occurrence table builder for one pair direction
// ----------------------------------------------------------------------------
// Takes one item per clock unless the output stalls: a pixel (tuser 0) or a
// table read (tuser 1). Pixels arrive in raster order; the unit tracks row
// and column itself and keeps the previous row's levels in two copies of a
// 1024x4 row buffer so that the entries at column c and c+1 can be read in
// the same cycle. Each item runs through a three-stage pipeline: accept (row
// buffer read and write), pair selection plus table read, then increment or
// clear with the write back. The table is a 256x20 ram; a back-to-back
// update of the same entry is covered by forwarding from the write-back
// stage, so there are no bubbles. A read result passes through stage 1,
// stage 2 and the output register before it shows on the master side.
// Table entries carry valid flags that reset clears at once, so the table
// reads as zero right after reset with no clearing pass; the row buffer has
// no reset. Counts saturate at 2^20-1. Configuration writes are taken any
// cycle but must only be made while the pipeline is empty.
// ----------------------------------------------------------------------------
module glcm_cooccurrence_accumulator_unit
    import glcm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    // input items
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_DATA_BITS-1:0]   s_tdata,   // pixel_value[7:0], read_first_level[11:8],
                                                 // read_second_level[15:12],
                                                 // clear_after_read[16], zero pad
    input  logic                      s_tuser,   // kind
    // result items
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_DATA_BITS-1:0]  m_tdata,   // entry_count[19:0], zero pad
    // configuration writes
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [1:0]           direction_reg;
    logic [SIZE_BITS-1:0] image_width_reg;
    logic [SIZE_BITS-1:0] image_height_reg;
    logic                 quantize_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg    <= DIR_HORIZONTAL;
            image_width_reg  <= SIZE_BITS'(MAX_WIDTH);
            image_height_reg <= SIZE_BITS'(HEIGHT_LIMIT);
            quantize_reg     <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DIRECTION:    direction_reg    <= cfg_data[1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_QUANTIZE:     quantize_reg     <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // out-of-range sizes act as the nearest legal size
    logic [SIZE_BITS-1:0] width_eff;
    logic [SIZE_BITS-1:0] height_eff;

    always_comb
    begin
        if (image_width_reg == '0)
            width_eff = SIZE_BITS'(1);
        else if (image_width_reg > SIZE_BITS'(MAX_WIDTH))
            width_eff = SIZE_BITS'(MAX_WIDTH);
        else
            width_eff = image_width_reg;

        if (image_height_reg == '0)
            height_eff = SIZE_BITS'(1);
        else if (image_height_reg > SIZE_BITS'(HEIGHT_LIMIT))
            height_eff = SIZE_BITS'(HEIGHT_LIMIT);
        else
            height_eff = image_height_reg;
    end

    // ------------------------------------------------------------------
    // flow control: the whole pipe moves when the output slot can take
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic out_valid_next;
    logic adv;
    logic s_fire;
    logic pix_fire;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;
    assign s_fire   = s_tvalid && s_tready;
    assign pix_fire = s_fire && (s_tuser == KIND_PIXEL);

    // input fields
    logic [PIXEL_BITS-1:0] in_pixel;
    level_t                in_first;
    level_t                in_second;
    logic                  in_clear;

    assign in_pixel  = s_tdata[7:0];
    assign in_first  = s_tdata[11:8];
    assign in_second = s_tdata[15:12];
    assign in_clear  = s_tdata[16];

    // ------------------------------------------------------------------
    // stage 0: raster position, level, row buffer access
    // ------------------------------------------------------------------
    logic [COL_BITS-1:0]  col_reg;
    logic [COL_BITS-1:0]  col_next;
    logic [ROW_BITS-1:0]  row_reg;
    logic [ROW_BITS-1:0]  row_next;
    level_t               left_level_reg;
    level_t               cur_level;
    logic [SIZE_BITS-1:0] col_plus;
    logic [SIZE_BITS-1:0] row_plus;
    logic                 pair_ok;

    assign cur_level = to_level(in_pixel, quantize_reg);
    assign col_plus  = SIZE_BITS'(col_reg) + SIZE_BITS'(1);
    assign row_plus  = SIZE_BITS'(row_reg) + SIZE_BITS'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_plus >= width_eff)
        begin
            // end of row, and of frame on the last row
            col_next = '0;
            row_next = (row_plus >= height_eff) ? '0 : row_plus[ROW_BITS-1:0];
        end
        else
        begin
            col_next = col_plus[COL_BITS-1:0];
        end
    end

    // whether the pixel has a reference partner at all
    always_comb
    begin
        case (direction_reg)
            DIR_HORIZONTAL: pair_ok = (col_reg != '0);
            DIR_VERTICAL:   pair_ok = (row_reg != '0);
            DIR_DIAG_45:    pair_ok = (row_reg != '0) && (col_reg != '0);
            default:        pair_ok = (row_reg != '0) && (col_plus < width_eff)
                                      && (col_plus < SIZE_BITS'(MAX_WIDTH));
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            left_level_reg <= '0;
        end
        else if (pix_fire)
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            left_level_reg <= cur_level;
        end
    end

    // two copies of the previous row: one read at c (above), one at c+1
    level_t above_level;
    level_t above_right_level;

    glcm_ram #(
        .WIDTH (LEVEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_above (
        .clk     (clk),
        .wr_en   (pix_fire),
        .wr_addr (col_reg),
        .wr_data (cur_level),
        .rd_en   (pix_fire),
        .rd_addr (col_reg),
        .rd_data (above_level)
    );

    glcm_ram #(
        .WIDTH (LEVEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_above_right (
        .clk     (clk),
        .wr_en   (pix_fire),
        .wr_addr (col_reg),
        .wr_data (cur_level),
        .rd_en   (pix_fire),
        .rd_addr (col_plus[COL_BITS-1:0]),
        .rd_data (above_right_level)
    );

    // ------------------------------------------------------------------
    // stage 1: pick the reference level, issue the table read
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    logic        s1_pixel_reg;
    logic [1:0]  s1_dir_reg;
    logic        s1_pair_reg;
    level_t      s1_cur_reg;
    level_t      s1_left_reg;
    level_t      s1_first_reg;
    level_t      s1_second_reg;
    logic        s1_clear_reg;
    level_t      diag_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_pixel_reg  <= (s_tuser == KIND_PIXEL);
            s1_dir_reg    <= direction_reg;
            s1_pair_reg   <= pair_ok;
            s1_cur_reg    <= cur_level;
            s1_left_reg   <= left_level_reg;
            s1_first_reg  <= in_first;
            s1_second_reg <= in_second;
            s1_clear_reg  <= in_clear;
        end
    end

    level_t      ref_level;
    table_addr_t s1_addr;
    logic        s1_write;
    logic        s1_move;

    always_comb
    begin
        case (s1_dir_reg)
            DIR_HORIZONTAL: ref_level = s1_left_reg;
            DIR_VERTICAL:   ref_level = above_level;
            DIR_DIAG_45:    ref_level = diag_level_reg;
            default:        ref_level = above_right_level;
        endcase
    end

    assign s1_addr  = s1_pixel_reg ? {ref_level, s1_cur_reg} : {s1_first_reg, s1_second_reg};
    assign s1_write = s1_pixel_reg ? s1_pair_reg : s1_clear_reg;
    assign s1_move  = adv && s1_valid_reg;

    // row-above level of the previous pixel, i.e. the up-left neighbor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_level_reg <= '0;
        end
        else if (s1_move && s1_pixel_reg)
        begin
            diag_level_reg <= above_level;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: increment or clear, write back, hand out read results
    // ------------------------------------------------------------------
    logic        s2_valid_reg;
    logic        s2_pixel_reg;
    logic        s2_write_reg;
    table_addr_t s2_addr_reg;
    logic        s2_fwd_hit_reg;
    count_t      s2_fwd_data_reg;
    logic        s2_entry_valid_reg;
    count_t      table_rd_data;
    count_t      s2_old;
    count_t      s2_new;
    logic        s2_wr_en;
    logic [TABLE_DEPTH-1:0] table_valid_reg;

    glcm_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (s2_wr_en),
        .wr_addr (s2_addr_reg),
        .wr_data (s2_new),
        .rd_en   (s1_move),
        .rd_addr (s1_addr),
        .rd_data (table_rd_data)
    );

    // an entry never written since reset reads as zero
    always_comb
    begin
        if (s2_fwd_hit_reg)
            s2_old = s2_fwd_data_reg;
        else if (s2_entry_valid_reg)
            s2_old = table_rd_data;
        else
            s2_old = '0;
    end

    assign s2_new   = s2_pixel_reg ? ((s2_old == COUNT_MAX) ? s2_old : s2_old + count_t'(1))
                                   : '0;
    assign s2_wr_en = adv && s2_valid_reg && s2_write_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg    <= 1'b0;
            table_valid_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s2_wr_en)
            begin
                table_valid_reg[s2_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_pixel_reg       <= s1_pixel_reg;
            s2_write_reg       <= s1_write;
            s2_addr_reg        <= s1_addr;
            s2_entry_valid_reg <= table_valid_reg[s1_addr];
            // the write leaving stage 2 now is missed by the ram read
            s2_fwd_hit_reg     <= s2_wr_en && (s2_addr_reg == s1_addr);
            s2_fwd_data_reg    <= s2_new;
        end
    end

    // output register
    count_t out_count_reg;

    assign out_valid_next = adv ? (s2_valid_reg && !s2_pixel_reg) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg && !s2_pixel_reg)
        begin
            out_count_reg <= s2_old;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_BITS - OUT_BITS){1'b0}}, out_count_reg[OUT_BITS-1:0]};

endmodule

// ===== design/glcm_checker.sv =====
// ----------------------------------------------------------------------------
// glcm_checker
// port-level checks of the co-occurrence accumulator, bound to the top level
// ----------------------------------------------------------------------------
module glcm_checker
    import glcm_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      s_tuser,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [OUT_DATA_BITS-1:0]  m_tdata
);

    // a waiting result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // a waiting result keeps its count
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // an empty output slot never blocks input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with output slot empty");

    // a read item reaches the output through stage 1, stage 2 and the output register when nothing stalls
    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == KIND_READ)) ##1 m_tready ##1 m_tready
        |=> m_tvalid)
        else $error("read result missing");

endmodule

bind glcm_cooccurrence_accumulator_unit glcm_checker u_glcm_checker (.*);
